@@ hw/rtl/qmu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qmu_pkg
// Shared types and codes for the queued mutex unit: request codes, result
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package qmu_pkg;

	// field widths fixed by the item format
	localparam int OP_W     = 2;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 3;
	localparam int WAIT_W   = 5;

	// request codes; bit 1 set always means unlock
	localparam logic [OP_W-1:0] OP_LOCK    = 2'd0;
	localparam logic [OP_W-1:0] OP_TRYLOCK = 2'd1;
	localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd2;
	localparam int              OP_UNLOCK_BIT = 1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ACQUIRED   = 3'd0,
		ST_QUEUED     = 3'd1,
		ST_TRY_BUSY   = 3'd2,
		ST_RELEASED   = 3'd3,
		ST_NOT_HOLDER = 3'd4,
		ST_NOT_LOCKED = 3'd5,
		ST_QUEUE_FULL = 3'd6
	} qmu_status_t;

	// controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} qmu_state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the incoming request
		logic execute;   // apply the request and load the result register
	} qmu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // result register can take a new result this cycle
	} qmu_stat_t;

endpackage : qmu_pkg
`default_nettype wire

@@ hw/rtl/qmu_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qmu_ctrl
// Request sequencer: takes one request, waits for the result register to be
// free, then has the datapath apply the request.
// ----------------------------------------------------------------------------
module qmu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire qmu_pkg::qmu_stat_t stat,
	output qmu_pkg::qmu_cmd_t      cmd
);

	qmu_pkg::qmu_state_t state_q;
	qmu_pkg::qmu_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qmu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			qmu_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = qmu_pkg::S_EXEC;
				end
			end
			qmu_pkg::S_EXEC: begin
				if (stat.out_free) begin
					state_d = qmu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = qmu_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			qmu_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			qmu_pkg::S_EXEC: begin
				cmd.execute = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule : qmu_ctrl
`default_nettype wire

@@ hw/rtl/qmu_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qmu_dpath
// Mutex state, waiter queue memory with head/tail pointers and count, and
// the result register on the output side.
// ----------------------------------------------------------------------------
module qmu_dpath #(
	parameter int MAX_WAITERS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire qmu_pkg::qmu_cmd_t              cmd,
	output qmu_pkg::qmu_stat_t                  stat,
	input  wire logic [qmu_pkg::OP_W-1:0]       in_op,
	input  wire logic [qmu_pkg::ID_W-1:0]       in_pid,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [qmu_pkg::STATUS_W-1:0]        out_status,
	output logic                                out_handoff_valid,
	output logic [qmu_pkg::ID_W-1:0]            out_handoff_id,
	output logic                                out_locked,
	output logic [qmu_pkg::ID_W-1:0]            out_holder,
	output logic [qmu_pkg::WAIT_W-1:0]          out_waiters
);

	localparam int PTR_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int CNT_W = $clog2(MAX_WAITERS + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_WAITERS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_WAITERS);

	// latched request
	logic [qmu_pkg::OP_W-1:0] op_q;
	logic [qmu_pkg::ID_W-1:0] pid_q;

	// mutex and queue state
	logic                     held_q;
	logic [qmu_pkg::ID_W-1:0] holder_q;
	logic [PTR_W-1:0]         head_q;
	logic [PTR_W-1:0]         tail_q;
	logic [CNT_W-1:0]         count_q;

	// waiter memory
	logic [qmu_pkg::ID_W-1:0] wait_mem [MAX_WAITERS];
	logic [qmu_pkg::ID_W-1:0] head_rd_q;

	// next values
	logic                     held_d;
	logic [qmu_pkg::ID_W-1:0] holder_d;
	logic [PTR_W-1:0]         head_d;
	logic [PTR_W-1:0]         tail_d;
	logic [CNT_W-1:0]         count_d;
	logic                     push;
	qmu_pkg::qmu_status_t     status_d;
	logic                     hv_d;
	logic [qmu_pkg::ID_W-1:0] hid_d;
	logic [CNT_W+qmu_pkg::WAIT_W-1:0] count_ext;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_op;
			pid_q <= in_pid;
		end
	end

	// queue memory: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (cmd.execute && push) begin
			wait_mem[tail_q] <= pid_q;
		end
		head_rd_q <= wait_mem[head_q];
	end

	// request decode and next state
	always_comb begin
		held_d   = held_q;
		holder_d = holder_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		push     = 1'b0;
		hv_d     = 1'b0;
		hid_d    = '0;
		status_d = qmu_pkg::ST_ACQUIRED;
		if (op_q[qmu_pkg::OP_UNLOCK_BIT]) begin
			if (!held_q) begin
				status_d = qmu_pkg::ST_NOT_LOCKED;
			end else if (holder_q != pid_q) begin
				status_d = qmu_pkg::ST_NOT_HOLDER;
			end else begin
				status_d = qmu_pkg::ST_RELEASED;
				if (count_q != '0) begin
					// hand over to the oldest waiter
					holder_d = head_rd_q;
					head_d   = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
					count_d  = count_q - 1'b1;
					hv_d     = 1'b1;
					hid_d    = head_rd_q;
				end else begin
					held_d   = 1'b0;
					holder_d = '0;
				end
			end
		end else if (!held_q) begin
			held_d   = 1'b1;
			holder_d = pid_q;
			status_d = qmu_pkg::ST_ACQUIRED;
		end else if (op_q == qmu_pkg::OP_TRYLOCK) begin
			status_d = qmu_pkg::ST_TRY_BUSY;
		end else if (count_q == FULL_CNT) begin
			status_d = qmu_pkg::ST_QUEUE_FULL;
		end else begin
			push     = 1'b1;
			tail_d   = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
			count_d  = count_q + 1'b1;
			status_d = qmu_pkg::ST_QUEUED;
		end
	end

	// mutex state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			holder_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
		end else if (cmd.execute) begin
			held_q   <= held_d;
			holder_q <= holder_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
		end
	end

	assign count_ext = {{qmu_pkg::WAIT_W{1'b0}}, count_d};

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.execute) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			out_status        <= status_d;
			out_handoff_valid <= hv_d;
			out_handoff_id    <= hid_d;
			out_locked        <= held_d;
			out_holder        <= held_d ? holder_d : '0;
			out_waiters       <= count_ext[qmu_pkg::WAIT_W-1:0];
		end
	end

	assign stat.out_free = !out_valid || out_ready;

endmodule : qmu_dpath
`default_nettype wire

@@ hw/rtl/queued_mutex_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// queued_mutex_unit
// Hardware mutex with a FIFO of waiting process IDs: lock, trylock and
// unlock requests, each answered by one result item.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                                    | tuser
//  s_axis    | in  | [7:0] process_id                         | [1:0] operation
//  m_axis    | out | status, handoff_valid, handoff_id,       | -
//            |     | locked_now, holder_now, waiters_now      |
//
//  Each item has a capture step, then an execute step that reads the head of
//  the waiter memory through its registered read port, before the next is taken.
//  The execute step waits while the result register is full and not taken;
//  the result register lets the next item be accepted while a result waits.
//  Reset clears mutex state and queue pointers; the waiter memory is not
//  cleared and its read data is only used when the count is nonzero.
// ----------------------------------------------------------------------------
module queued_mutex_unit #(
	parameter int MAX_WAITERS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] process_id
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [2:0] status, [3] handoff_valid,
	                                          // [11:4] handoff_id, [12] locked_now,
	                                          // [20:13] holder_now, [25:21] waiters_now
);

	qmu_pkg::qmu_cmd_t  cmd;
	qmu_pkg::qmu_stat_t stat;

	logic [qmu_pkg::STATUS_W-1:0] res_status;
	logic                         res_hv;
	logic [qmu_pkg::ID_W-1:0]     res_hid;
	logic                         res_locked;
	logic [qmu_pkg::ID_W-1:0]     res_holder;
	logic [qmu_pkg::WAIT_W-1:0]   res_waiters;

	qmu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	qmu_dpath #(
		.MAX_WAITERS (MAX_WAITERS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_op             (s_axis_tuser),
		.in_pid            (s_axis_tdata),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_status        (res_status),
		.out_handoff_valid (res_hv),
		.out_handoff_id    (res_hid),
		.out_locked        (res_locked),
		.out_holder        (res_holder),
		.out_waiters       (res_waiters)
	);

	// pack result fields, highest first
	assign m_axis_tdata = {6'd0, res_waiters, res_holder, res_locked,
		res_hid, res_hv, res_status};

endmodule : queued_mutex_unit
`default_nettype wire

@@ bench/tb_queued_mutex_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_queued_mutex_unit
// Self-checking bench for the queued mutex unit. Lock, trylock and unlock
// requests go in on the slave stream. A behavioral copy of the mutex and its
// waiter queue predicts every result item, and each item leaving the master
// stream is compared field by field against the oldest prediction. Both
// streams idle at random. One phase holds the result side off for a long
// stretch so that the unit fills up and stalls its input; the waiter queue
// is then filled past its depth.
// ----------------------------------------------------------------------------
module tb_queued_mutex_unit;

	localparam int MAX_WAITERS  = 16;
	localparam int RANDOM_ITEMS = 1300;
	localparam int ID_POOL      = 6;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_GUARD  = 20000;

	// code three has bit 1 set, so the unit decodes it as unlock
	localparam logic [qmu_pkg::OP_W-1:0] OP_UNLOCK_ALT =
		qmu_pkg::OP_UNLOCK | qmu_pkg::OP_TRYLOCK;

	// result item layout, lowest field at the bottom
	typedef struct packed {
		logic [5:0]                   pad;
		logic [qmu_pkg::WAIT_W-1:0]   waiters_now;
		logic [qmu_pkg::ID_W-1:0]     holder_now;
		logic                         locked_now;
		logic [qmu_pkg::ID_W-1:0]     handoff_id;
		logic                         handoff_valid;
		logic [qmu_pkg::STATUS_W-1:0] status;
	} mutex_reply_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = '0;   // [7:0] process_id
	logic [1:0]       s_axis_tuser = '0;   // [1:0] operation
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [31:0]      m_axis_tdata;        // [2:0] status, [3] handoff_valid,
	                                       // [11:4] handoff_id, [12] locked_now,
	                                       // [20:13] holder_now, [25:21] waiters_now

	// predicted mutex state
	logic                     mutex_held = 1'b0;
	logic [qmu_pkg::ID_W-1:0] mutex_owner = '0;
	logic [qmu_pkg::ID_W-1:0] waiter_ids[$];

	mutex_reply_t    expected_replies[$];
	int              error_count = 0;

	// random idling on both streams, and the hold-off request for the sink
	logic            idle_on = 1'b0;
	int              hold_seq = 0;
	int              hold_seen = 0;
	int              hold_left = 0;

	always #5 clk = ~clk;

	queued_mutex_unit #(
		.MAX_WAITERS(MAX_WAITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// apply one request to the predicted mutex and return the result it gives
	function automatic mutex_reply_t mutex_apply(logic [qmu_pkg::OP_W-1:0] op,
			logic [qmu_pkg::ID_W-1:0] pid);
		mutex_reply_t r;
		logic [qmu_pkg::ID_W-1:0] next_owner;
		r = '0;
		if (op[qmu_pkg::OP_UNLOCK_BIT]) begin
			if (!mutex_held) begin
				r.status = qmu_pkg::ST_NOT_LOCKED;
			end else if (mutex_owner != pid) begin
				r.status = qmu_pkg::ST_NOT_HOLDER;
			end else begin
				r.status = qmu_pkg::ST_RELEASED;
				mutex_held = 1'b0;
				mutex_owner = '0;
				// oldest waiter takes over in the same step
				if (waiter_ids.size() != 0) begin
					next_owner = waiter_ids.pop_front();
					mutex_held = 1'b1;
					mutex_owner = next_owner;
					r.handoff_valid = 1'b1;
					r.handoff_id = next_owner;
				end
			end
		end else if (!mutex_held) begin
			mutex_held = 1'b1;
			mutex_owner = pid;
			r.status = qmu_pkg::ST_ACQUIRED;
		end else if (op == qmu_pkg::OP_TRYLOCK) begin
			r.status = qmu_pkg::ST_TRY_BUSY;
		end else if (waiter_ids.size() >= MAX_WAITERS) begin
			r.status = qmu_pkg::ST_QUEUE_FULL;
		end else begin
			waiter_ids.push_back(pid);
			r.status = qmu_pkg::ST_QUEUED;
		end
		r.locked_now = mutex_held;
		r.holder_now = mutex_held ? mutex_owner : '0;
		r.waiters_now = qmu_pkg::WAIT_W'(waiter_ids.size());
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// offer one request; tready is sampled mid-cycle, the handshake lands on
	// the following rising edge
	task automatic push_request(input logic [qmu_pkg::OP_W-1:0] op,
			input logic [qmu_pkg::ID_W-1:0] pid);
		logic taken;
		if (idle_on) begin
			while ($urandom_range(99) < 17) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pid;
		s_axis_tuser  <= op;
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			if (taken)
				expected_replies.push_back(mutex_apply(op, pid));
			@(posedge clk);
		end while (!taken);
	endtask

	// sink side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen     <= hold_seq;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(idle_on && $urandom_range(99) < 17);
		end
	end

	// compare each accepted result with the oldest prediction
	always @(negedge clk) begin : check_replies
		mutex_reply_t got;
		mutex_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_replies.size() == 0) begin
				$error("result item with nothing expected: %h", m_axis_tdata);
				error_count++;
			end else begin
				want = expected_replies.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("handoff_valid", 32'(want.handoff_valid),
					32'(got.handoff_valid));
				check_field("handoff_id", 32'(want.handoff_id), 32'(got.handoff_id));
				check_field("locked_now", 32'(want.locked_now), 32'(got.locked_now));
				check_field("holder_now", 32'(want.holder_now), 32'(got.holder_now));
				check_field("waiters_now", 32'(want.waiters_now),
					32'(got.waiters_now));
				check_field("tdata padding", 32'(want.pad), 32'(got.pad));
			end
		end
	end

	// every status code but queue full, holder relock, code three as unlock, extreme ids
	task automatic test_single_requests;
		push_request(qmu_pkg::OP_UNLOCK, 8'h00);   // unlock on a free mutex
		push_request(qmu_pkg::OP_TRYLOCK, 8'hFF);  // trylock takes a free mutex
		push_request(qmu_pkg::OP_TRYLOCK, 8'h00);  // trylock on a held mutex
		push_request(qmu_pkg::OP_LOCK, 8'h00);     // queued behind the holder
		push_request(qmu_pkg::OP_LOCK, 8'hFF);     // holder relocks, queued behind itself
		push_request(qmu_pkg::OP_UNLOCK, 8'h5A);   // unlock by a non-holder
		push_request(OP_UNLOCK_ALT, 8'hFF);        // release, handoff to 0x00
		push_request(qmu_pkg::OP_UNLOCK, 8'h00);   // handoff back to 0xFF
		push_request(OP_UNLOCK_ALT, 8'hFF);        // release with an empty queue
		push_request(OP_UNLOCK_ALT, 8'hFF);        // code three on a free mutex
		push_request(qmu_pkg::OP_LOCK, 8'hAA);
		push_request(qmu_pkg::OP_TRYLOCK, 8'h55);
		push_request(qmu_pkg::OP_UNLOCK, 8'h55);
		push_request(qmu_pkg::OP_UNLOCK, 8'hAA);
		push_request(qmu_pkg::OP_LOCK, 8'h55);
		push_request(qmu_pkg::OP_UNLOCK, 8'h55);
	endtask

	// sink stalls at the start; the queue is then filled past its depth
	// and drained
	task automatic test_queue_full;
		hold_seq <= hold_seq + 1;
		push_request(qmu_pkg::OP_LOCK, 8'h01);
		for (int i = 0; i < MAX_WAITERS + 2; i++)
			push_request(qmu_pkg::OP_LOCK, 8'h80 + 8'(i * 7));
		push_request(qmu_pkg::OP_TRYLOCK, 8'h7F);
		// each holder in turn hands the mutex to the next waiter
		while (mutex_held)
			push_request(qmu_pkg::OP_UNLOCK, mutex_owner);
	endtask

	// mostly well-formed traffic from a small set of ids, biased per chunk
	// toward filling or draining the queue, with some noise mixed in
	task automatic test_random_traffic;
		logic [qmu_pkg::ID_W-1:0] id_set[ID_POOL];
		logic [qmu_pkg::ID_W-1:0] pid;
		logic [qmu_pkg::OP_W-1:0] op;
		int lock_pct;
		int pick;
		idle_on <= 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				idle_on <= 1'b1;
			if (n % 100 == 0) begin
				lock_pct = $urandom_range(20, 65);
				foreach (id_set[k])
					id_set[k] = qmu_pkg::ID_W'($urandom);
			end
			pick = $urandom_range(99);
			pid = id_set[$urandom_range(ID_POOL - 1)];
			if (pick < 8) begin
				op = qmu_pkg::OP_W'($urandom_range(3));
				pid = qmu_pkg::ID_W'($urandom);
			end else if (pick < 8 + lock_pct) begin
				op = qmu_pkg::OP_LOCK;
			end else if (pick < 20 + lock_pct) begin
				op = qmu_pkg::OP_TRYLOCK;
			end else begin
				op = $urandom_range(1) ? qmu_pkg::OP_UNLOCK : OP_UNLOCK_ALT;
				if (mutex_held)
					pid = mutex_owner;
			end
			push_request(op, pid);
		end
	endtask

	initial begin : run_tests
		int guard;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on <= 1'b1;
		test_single_requests();
		test_queue_full();
		test_random_traffic();
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (expected_replies.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_replies.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ queued_mutex_unit.f @@
hw/rtl/qmu_pkg.sv
hw/rtl/qmu_ctrl.sv
hw/rtl/qmu_dpath.sv
hw/rtl/queued_mutex_unit.sv
bench/tb_queued_mutex_unit.sv
